[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the LED mode controller RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/lmbc_pkg.sv]
// ----------------------------------------------------------------------------
// lmbc_pkg
// Types, register indexes and mode codes of the LED mode controller.
// ----------------------------------------------------------------------------
package lmbc_pkg;

  localparam int TimeW   = 32;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_BLINK_INTERVAL  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE        = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LIT_HIGH        = 2'd2;

  localparam logic [TimeW-1:0] BlinkIntervalReset = TimeW'(500);
  localparam logic [TimeW-1:0] DebounceReset      = TimeW'(50);

  typedef enum logic [1:0] {
    MODE_BLINK = 2'd0,
    MODE_ON    = 2'd1,
    MODE_OFF   = 2'd2
  } mode_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             button_edge;
    logic             button_level;
  } item_t;

  typedef struct packed {
    logic       led_level;
    logic [1:0] current_mode;
    logic       button_armed;
  } result_t;

  typedef struct packed {
    logic [TimeW-1:0] blink_period;
    logic [TimeW-1:0] quiet_time;
    logic             lit_high;
  } cfg_t;

  function automatic mode_t next_mode(mode_t m);
    mode_t n;
    case (m)
      MODE_BLINK: n = MODE_ON;
      MODE_ON:    n = MODE_OFF;
      default:    n = MODE_BLINK;
    endcase
    return n;
  endfunction

endpackage

[rtl/led_mode_blink_controller.sv]
// ----------------------------------------------------------------------------
// led_mode_blink_controller
// Button-driven LED mode cycler with debounce and blink timer.
//
//   port group   direction   handshake              payload
//   item         in          item_valid/item_stall  now_ms, button_edge, button_level
//   result       out         result_valid/result_stall led_level, current_mode, button_armed
//   cfg          in          cfg_we                 cfg_index, cfg_data
//
// One word per clock sustained while the result is not stalled; a word is
// captured in the input register, passed through the update logic, and its
// result is loaded into the result register. Reset is synchronous and clears
// the mode and timer state and loads the default configuration. A stalled
// result holds; the input register keeps taking words while it can drain.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module led_mode_blink_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  lmbc_pkg::item_t               item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output lmbc_pkg::result_t             result,
  input  logic                          cfg_we,
  input  logic [lmbc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [lmbc_pkg::CfgDataW-1:0] cfg_data
);

  lmbc_pkg::cfg_t    cfg;
  lmbc_pkg::item_t   item_r;
  lmbc_pkg::result_t result_next;
  logic              in_full;
  logic              advance;

  assign advance    = in_full && (!result_valid || !result_stall);
  assign item_stall = in_full && result_valid && result_stall;

  lmbc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lmbc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (item_r),
    .cfg    (cfg),
    .result (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_valid && !item_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_r <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  `ASSERT_IMPLIES(a_stall_from_output, clk, rst, item_stall,
                  result_valid && result_stall, "input stalled while result can drain")
  `ASSERT_NEXT(a_advance_fills_result, clk, rst, advance,
               result_valid, "processed word did not reach result register")
  `ASSERT_NEXT(a_full_until_advance, clk, rst, in_full && !advance,
               in_full, "input word dropped before processing")

endmodule

[rtl/lmbc_cfg.sv]
// ----------------------------------------------------------------------------
// lmbc_cfg
// Configuration registers: blink interval, debounce time, LED polarity.
// ----------------------------------------------------------------------------
module lmbc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lmbc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [lmbc_pkg::CfgDataW-1:0] cfg_data,
  output lmbc_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blink_period <= lmbc_pkg::BlinkIntervalReset;
      cfg.quiet_time   <= lmbc_pkg::DebounceReset;
      cfg.lit_high     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        lmbc_pkg::REG_BLINK_INTERVAL: cfg.blink_period <= cfg_data[lmbc_pkg::TimeW-1:0];
        lmbc_pkg::REG_DEBOUNCE:       cfg.quiet_time   <= cfg_data[lmbc_pkg::TimeW-1:0];
        lmbc_pkg::REG_LIT_HIGH:       cfg.lit_high     <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/lmbc_core.sv]
// ----------------------------------------------------------------------------
// lmbc_core
// Mode, debounce and blink state with its single-pass update logic.
// ----------------------------------------------------------------------------
module lmbc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  lmbc_pkg::item_t   item,
  input  lmbc_pkg::cfg_t    cfg,
  output lmbc_pkg::result_t result
);

  lmbc_pkg::mode_t              mode, mode_next;
  logic [lmbc_pkg::TimeW-1:0]   last_toggle_time, last_toggle_time_next;
  logic [lmbc_pkg::TimeW-1:0]   last_edge_time, last_edge_time_next;
  logic                         awaiting_release, awaiting_release_next;
  logic                         led_lit, led_lit_next;
  logic [lmbc_pkg::TimeW-1:0]   edge_gap;
  logic [lmbc_pkg::TimeW-1:0]   toggle_gap;

  always_comb begin
    mode_next             = mode;
    last_toggle_time_next = last_toggle_time;
    last_edge_time_next   = last_edge_time;
    awaiting_release_next = awaiting_release;
    led_lit_next          = led_lit;

    if (item.button_edge) begin
      last_edge_time_next = item.now_ms;
      if (!awaiting_release) begin
        awaiting_release_next = 1'b1;
        mode_next             = lmbc_pkg::next_mode(mode);
        last_toggle_time_next = item.now_ms;
      end
    end

    edge_gap = item.now_ms - last_edge_time_next;
    if (awaiting_release_next && item.button_level && (edge_gap >= cfg.quiet_time)) begin
      awaiting_release_next = 1'b0;
    end

    toggle_gap = item.now_ms - last_toggle_time_next;
    case (mode_next)
      lmbc_pkg::MODE_BLINK: begin
        if (toggle_gap >= cfg.blink_period) begin
          last_toggle_time_next = item.now_ms;
          led_lit_next          = !led_lit;
        end
      end
      lmbc_pkg::MODE_ON: led_lit_next = 1'b1;
      default:           led_lit_next = 1'b0;
    endcase
  end

  always_comb begin
    result.led_level    = (led_lit_next == cfg.lit_high);
    result.current_mode = mode_next;
    result.button_armed = !awaiting_release_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= lmbc_pkg::MODE_BLINK;
      last_toggle_time <= '0;
      last_edge_time   <= '0;
      awaiting_release <= 1'b0;
      led_lit          <= 1'b0;
    end else if (fire) begin
      mode             <= mode_next;
      last_toggle_time <= last_toggle_time_next;
      last_edge_time   <= last_edge_time_next;
      awaiting_release <= awaiting_release_next;
      led_lit          <= led_lit_next;
    end
  end

endmodule
